// ----- design/rtp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types, constants and helpers of the radix integer text parser.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam longint unsigned COUNT_MAX_DEF = 64'd65535;

  localparam int VAL_W  = 64;
  localparam int CONS_W = 16;
  localparam int BASE_W = 5;
  localparam int CH_W   = 8;

  localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CH_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CH_W-1:0] CH_PLUS    = 8'h2b;
  localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CH_W-1:0] CH_X_LO    = 8'h78;
  localparam logic [CH_W-1:0] CH_X_UP    = 8'h58;
  localparam logic [CH_W-1:0] CH_A_LO    = 8'h61;
  localparam logic [CH_W-1:0] CH_F_LO    = 8'h66;
  localparam logic [CH_W-1:0] CH_A_UP    = 8'h41;
  localparam logic [CH_W-1:0] CH_F_UP    = 8'h46;

  localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
  localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
  localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;
  localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  typedef struct packed {
    logic              emit;
    logic [VAL_W-1:0]  value;
    logic [CONS_W-1:0] consumed;
    logic              overflow;
  } result_t;

  function automatic digit_t digit_of(input logic [CH_W-1:0] c);
    digit_t d;
    logic [CH_W-1:0] t;
    d = '0;
    t = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      d.ok = 1'b1;
      d.val = t[3:0];
    end else if (c >= CH_A_LO && c <= CH_F_LO) begin
      t = c - CH_A_LO + 8'd10;
      d.ok = 1'b1;
      d.val = t[3:0];
    end else if (c >= CH_A_UP && c <= CH_F_UP) begin
      t = c - CH_A_UP + 8'd10;
      d.ok = 1'b1;
      d.val = t[3:0];
    end
    return d;
  endfunction

endpackage

// ----- design/rtp_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_mac
// Accumulate step: acc * base + digit, modulo 2^64, with signed range check.
// ----------------------------------------------------------------------------
module rtp_mac (
  input  logic [rtp_pkg::VAL_W-1:0]  acc_i,
  input  logic [rtp_pkg::BASE_W-1:0] base_i,
  input  logic [3:0]                 digit_i,
  output logic [rtp_pkg::VAL_W-1:0]  acc_o,
  output logic                       wrap_o
);

  localparam int PROD_W = rtp_pkg::VAL_W + rtp_pkg::BASE_W;

  logic [PROD_W-1:0] prod;

  // exact product plus digit; anything at bit 63 or above is past the signed max
  assign prod   = PROD_W'(acc_i) * PROD_W'(base_i) + PROD_W'(digit_i);
  assign acc_o  = prod[rtp_pkg::VAL_W-1:0];
  assign wrap_o = |prod[PROD_W-1:rtp_pkg::VAL_W-1];

endmodule

// ----- design/rtp_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_fsm
// Per-string parse state and the combinational character step.
// ----------------------------------------------------------------------------
module rtp_fsm #(
  parameter longint unsigned COUNT_MAX = rtp_pkg::COUNT_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [rtp_pkg::CH_W-1:0]   ch,
  input  logic                       start_req,
  input  logic [rtp_pkg::BASE_W-1:0] radix,
  output rtp_pkg::result_t           res
);

  localparam int CNT_W = $clog2(COUNT_MAX + 64'd1);

  typedef enum logic [2:0] {
    PH_DONE,
    PH_LEAD,
    PH_SIGN,
    PH_ZERO,
    PH_DIGIT
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic                       neg_r, neg_nxt;
  logic [rtp_pkg::BASE_W-1:0] base_r, base_nxt;
  logic [rtp_pkg::VAL_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       wrap_r, wrap_nxt;

  // prefix stage results
  phase_t                     ph_d;
  logic                       neg_d;
  logic [rtp_pkg::BASE_W-1:0] base_d;
  logic [rtp_pkg::VAL_W-1:0]  acc_d;
  logic [CNT_W-1:0]           cnt_d;
  logic                       wrap_d;
  logic                       go_d;

  rtp_pkg::digit_t            dig;
  logic [rtp_pkg::VAL_W-1:0]  mac_acc;
  logic                       mac_wrap;
  logic [63:0]                cnt_ext;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c < CNT_W'(COUNT_MAX)) ? c + CNT_W'(1) : c;
  endfunction

  assign dig = rtp_pkg::digit_of(ch);

  // leading spaces, sign and auto prefix
  always_comb begin
    ph_d   = start_req ? PH_LEAD : phase_r;
    neg_d  = start_req ? 1'b0 : neg_r;
    base_d = start_req ? radix : base_r;
    acc_d  = start_req ? '0 : acc_r;
    cnt_d  = start_req ? '0 : cnt_r;
    wrap_d = start_req ? 1'b0 : wrap_r;
    go_d   = 1'b1;
    if (ph_d == PH_LEAD) begin
      if (ch == rtp_pkg::CH_SPACE) begin
        cnt_d = bump(cnt_d);
        go_d  = 1'b0;
      end else if (ch == rtp_pkg::CH_MINUS) begin
        neg_d = 1'b1;
        cnt_d = bump(cnt_d);
        ph_d  = PH_SIGN;
        go_d  = 1'b0;
      end else if (ch == rtp_pkg::CH_PLUS) begin
        cnt_d = bump(cnt_d);
        ph_d  = PH_SIGN;
        go_d  = 1'b0;
      end else begin
        ph_d = PH_SIGN;
      end
    end
    if (go_d && ph_d == PH_SIGN) begin
      if (base_d == rtp_pkg::BASE_AUTO && ch == rtp_pkg::CH_ZERO) begin
        cnt_d = bump(cnt_d);
        ph_d  = PH_ZERO;
        go_d  = 1'b0;
      end else begin
        if (base_d == rtp_pkg::BASE_AUTO) begin
          base_d = rtp_pkg::BASE_DEC;
        end
        ph_d = PH_DIGIT;
      end
    end
    if (go_d && ph_d == PH_ZERO) begin
      if (ch == rtp_pkg::CH_X_LO || ch == rtp_pkg::CH_X_UP) begin
        base_d = rtp_pkg::BASE_HEX;
        cnt_d  = bump(cnt_d);
        go_d   = 1'b0;
      end else begin
        base_d = rtp_pkg::BASE_OCT;
      end
      ph_d = PH_DIGIT;
    end
  end

  rtp_mac u_mac (
    .acc_i   (acc_d),
    .base_i  (base_d),
    .digit_i (dig.val),
    .acc_o   (mac_acc),
    .wrap_o  (mac_wrap)
  );

  // digit accumulation or stop
  always_comb begin
    phase_nxt    = ph_d;
    neg_nxt      = neg_d;
    base_nxt     = base_d;
    acc_nxt      = acc_d;
    cnt_nxt      = cnt_d;
    wrap_nxt     = wrap_d;
    cnt_ext      = 64'(cnt_d);
    res.emit     = 1'b0;
    res.value    = neg_d ? ('0 - acc_d) : acc_d;
    res.consumed = cnt_ext[rtp_pkg::CONS_W-1:0];
    res.overflow = wrap_d;
    if (go_d) begin
      case (ph_d)
        PH_DIGIT: begin
          if (dig.ok && rtp_pkg::BASE_W'(dig.val) < base_d) begin
            acc_nxt  = mac_acc;
            wrap_nxt = wrap_d | mac_wrap;
            cnt_nxt  = bump(cnt_d);
          end else begin
            res.emit  = 1'b1;
            phase_nxt = PH_DONE;
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      neg_r   <= 1'b0;
      base_r  <= rtp_pkg::BASE_DEC;
      wrap_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      base_r  <= base_nxt;
      wrap_r  <= wrap_nxt;
    end
  end

  // accumulator and count are cleared by every start
  always_ff @(posedge clk) begin
    if (step_en) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- design/radix_integer_text_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_text_parser
// Streaming strtol-style integer parser, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one character (in_ch), a start flag (in_start_req)
//   and a radix (in_radix, sampled with start; 0 selects auto detection).
//   A start opens a new string and drops any unfinished one. The first
//   character that is not part of the number closes the string and gives
//   one output beat: signed value, characters consumed and overflow flag.
//   Characters after that give nothing until the next start.
//   A closing character reaches the output through the input register,
//   then the result register.
//   Throughput: one character per cycle while the receiver does not stall;
//   the accumulate step (acc * base + digit with range check) is combinational.
//   When the receiver stalls, the result register holds its beat, the
//   input register holds the next character and in_ready drops once both
//   are full. Reset returns the parser to waiting for a start and empties
//   both registers.
// ----------------------------------------------------------------------------
module radix_integer_text_parser #(
  parameter longint unsigned COUNT_MAX = rtp_pkg::COUNT_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rtp_pkg::CH_W-1:0]    in_ch,
  input  logic                        in_start_req,
  input  logic [rtp_pkg::BASE_W-1:0]  in_radix,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [rtp_pkg::VAL_W-1:0] out_value,
  output logic [rtp_pkg::CONS_W-1:0]  out_consumed,
  output logic                        out_overflow
);

  logic                       in_valid_r, in_valid_nxt;
  logic [rtp_pkg::CH_W-1:0]   ch_r;
  logic                       start_r;
  logic [rtp_pkg::BASE_W-1:0] radix_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [rtp_pkg::VAL_W-1:0]  value_r;
  logic [rtp_pkg::CONS_W-1:0] consumed_r;
  logic                       overflow_r;

  logic                       adv;
  logic                       step_go;
  logic                       in_acc;
  rtp_pkg::result_t           res;

  assign adv      = !out_valid_r || out_ready;
  assign step_go  = in_valid_r && adv;
  assign in_ready = !in_valid_r || step_go;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (step_go) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = step_go && res.emit;
    end
  end

  rtp_fsm #(
    .COUNT_MAX (COUNT_MAX)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_go),
    .ch        (ch_r),
    .start_req (start_r),
    .radix     (radix_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r    <= in_ch;
      start_r <= in_start_req;
      radix_r <= in_radix;
    end
    if (adv && step_go && res.emit) begin
      value_r    <= res.value;
      consumed_r <= res.consumed;
      overflow_r <= res.overflow;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = value_r;
  assign out_consumed = consumed_r;
  assign out_overflow = overflow_r;

`ifndef SYNTHESIS
  a_reset_empties_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result register not empty after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> (in_ready == !in_valid_r))
    else $error("input side moved while result stalled");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r))
    else $error("result beat without a character in the input register");

  a_held_char_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !step_go) |=> (in_valid_r && $stable(ch_r) && $stable(start_r)))
    else $error("held character lost before it was stepped");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radix integer text parser: character strings
// are queued up front, fed through a valid/ready driver with random gaps and
// the parsed integers are predicted in the bench and compared beat by beat.
// ----------------------------------------------------------------------------
module tb;

  localparam int          CLK_HALF   = 6;
  localparam int          LIVE_CHARS = 1750;
  localparam int          QUIET_LO   = 500;
  localparam int          QUIET_HI   = 1500;
  localparam int          LIMIT      = 1000000;
  localparam int          TAIL       = 10;
  localparam int          MAX_SHOWN  = 10;
  localparam logic [63:0] SMAX       = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {PH_IDLE, PH_LEAD, PH_SIGN, PH_ZERO, PH_DIGIT} parse_phase_t;

  typedef struct {
    logic [rtp_pkg::CH_W-1:0]   ch;
    logic                       start;
    logic [rtp_pkg::BASE_W-1:0] radix;
    bit                         hold;
  } char_item_t;

  typedef struct {
    logic [rtp_pkg::VAL_W-1:0]  value;
    logic [rtp_pkg::CONS_W-1:0] consumed;
    logic                       overflow;
  } parse_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [rtp_pkg::CH_W-1:0]          in_ch = '0;
  logic                              in_start_req = 1'b0;
  logic [rtp_pkg::BASE_W-1:0]        in_radix = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [rtp_pkg::VAL_W-1:0]  out_value;
  logic [rtp_pkg::CONS_W-1:0]        out_consumed;
  logic                              out_overflow;

  char_item_t    char_queue[$];
  parse_result_t parsed_results[$];
  char_item_t    cur_item;
  int            cycle = 0;
  int            errors = 0;
  int            n_live = 0;
  bit            opening = 1'b0;
  bit            hold_req = 1'b0;
  logic [rtp_pkg::BASE_W-1:0] str_radix = '0;

  // parser state as the bench sees it
  parse_phase_t               ph_r = PH_IDLE;
  logic                       neg_r = 1'b0;
  logic [rtp_pkg::BASE_W-1:0] base_r = rtp_pkg::BASE_DEC;
  logic [rtp_pkg::VAL_W-1:0]  acc_r = '0;
  longint unsigned            count_r = 0;
  logic                       ovf_r = 1'b0;

  radix_integer_text_parser i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .in_start_req (in_start_req),
    .in_radix     (in_radix),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_consumed (out_consumed),
    .out_overflow (out_overflow)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic bit take_break();
    if (cycle >= QUIET_LO && cycle < QUIET_HI) return 1'b0;
    return $urandom_range(0, 99) < 15;
  endfunction

  function automatic int char_digit(input logic [rtp_pkg::CH_W-1:0] c);
    if (c >= rtp_pkg::CH_ZERO && c <= rtp_pkg::CH_NINE) return int'(c - rtp_pkg::CH_ZERO);
    if (c >= rtp_pkg::CH_A_LO && c <= rtp_pkg::CH_F_LO) return int'(c - rtp_pkg::CH_A_LO) + 10;
    if (c >= rtp_pkg::CH_A_UP && c <= rtp_pkg::CH_F_UP) return int'(c - rtp_pkg::CH_A_UP) + 10;
    return -1;
  endfunction

  function automatic void bump_count();
    if (count_r < rtp_pkg::COUNT_MAX_DEF) count_r++;
  endfunction

  // advance the parser by one character, queueing the integer it closes
  function automatic void parse_char(input char_item_t it);
    int              d;
    bit              stop;
    longint unsigned dv;
    longint unsigned bv;
    parse_result_t   r;
    if (it.start) begin
      ph_r = PH_LEAD;
      neg_r = 1'b0;
      base_r = it.radix;
      acc_r = '0;
      count_r = 0;
      ovf_r = 1'b0;
    end
    stop = 1'b0;
    while (!stop) begin
      case (ph_r)
        PH_LEAD: begin
          if (it.ch == rtp_pkg::CH_SPACE) begin
            bump_count();
            stop = 1'b1;
          end else if (it.ch == rtp_pkg::CH_MINUS || it.ch == rtp_pkg::CH_PLUS) begin
            neg_r = (it.ch == rtp_pkg::CH_MINUS);
            bump_count();
            ph_r = PH_SIGN;
            stop = 1'b1;
          end else begin
            ph_r = PH_SIGN;
          end
        end
        PH_SIGN: begin
          if (base_r == rtp_pkg::BASE_AUTO) begin
            if (it.ch == rtp_pkg::CH_ZERO) begin
              bump_count();
              ph_r = PH_ZERO;
              stop = 1'b1;
            end else begin
              base_r = rtp_pkg::BASE_DEC;
            end
          end
          if (!stop) ph_r = PH_DIGIT;
        end
        PH_ZERO: begin
          ph_r = PH_DIGIT;
          if (it.ch == rtp_pkg::CH_X_LO || it.ch == rtp_pkg::CH_X_UP) begin
            base_r = rtp_pkg::BASE_HEX;
            bump_count();
            stop = 1'b1;
          end else begin
            base_r = rtp_pkg::BASE_OCT;
          end
        end
        PH_DIGIT: begin
          d = char_digit(it.ch);
          if (d >= 0 && d < int'(base_r)) begin
            dv = 64'(d);
            bv = 64'(base_r);
            if (acc_r > (SMAX - dv) / bv) ovf_r = 1'b1;
            acc_r = acc_r * bv + dv;
            bump_count();
          end else begin
            r.value = neg_r ? (64'd0 - acc_r) : acc_r;
            r.consumed = count_r[rtp_pkg::CONS_W-1:0];
            r.overflow = ovf_r;
            parsed_results.push_back(r);
            ph_r = PH_IDLE;
          end
          stop = 1'b1;
        end
        default: begin
          ph_r = PH_IDLE;
          stop = 1'b1;
        end
      endcase
    end
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("tb: %s", msg);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic open_string(input logic [rtp_pkg::BASE_W-1:0] r);
    opening = 1'b1;
    str_radix = r;
  endtask

  task automatic put_char(input logic [rtp_pkg::CH_W-1:0] c, input bit live = 1'b1);
    char_item_t it;
    it.ch = c;
    it.start = opening;
    it.radix = opening ? str_radix : rtp_pkg::BASE_W'($urandom_range(0, 31));
    it.hold = hold_req;
    char_queue.push_back(it);
    opening = 1'b0;
    hold_req = 1'b0;
    if (live) n_live++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [rtp_pkg::CH_W-1:0] digit_char(input int v);
    if (v < 10) return rtp_pkg::CH_ZERO + rtp_pkg::CH_W'(v);
    return ($urandom_range(0, 1) ? rtp_pkg::CH_A_LO : rtp_pkg::CH_A_UP) +
           rtp_pkg::CH_W'(v - 10);
  endfunction

  function automatic logic [rtp_pkg::CH_W-1:0] stop_char();
    logic [rtp_pkg::CH_W-1:0] c;
    do c = rtp_pkg::CH_W'($urandom_range(0, 255)); while (char_digit(c) >= 0);
    return c;
  endfunction

  task automatic random_string();
    logic [rtp_pkg::BASE_W-1:0] r;
    int                         sel;
    int                         base;
    int                         nd;
    int                         ends;
    sel = $urandom_range(0, 19);
    if (sel < 8) begin
      r = rtp_pkg::BASE_AUTO;
    end else if (sel < 10) begin
      r = rtp_pkg::BASE_W'($urandom_range(1, 31));
    end else if (sel < 16) begin
      case ($urandom_range(0, 3))
        0: r = 5'd2;
        1: r = rtp_pkg::BASE_OCT;
        2: r = rtp_pkg::BASE_DEC;
        default: r = rtp_pkg::BASE_HEX;
      endcase
    end else begin
      r = rtp_pkg::BASE_W'($urandom_range(2, 16));
    end
    open_string(r);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put_char(rtp_pkg::CH_SPACE);
    case ($urandom_range(0, 3))
      0: put_char(rtp_pkg::CH_MINUS);
      1: put_char(rtp_pkg::CH_PLUS);
      default: ;
    endcase
    base = int'(r);
    if (r == rtp_pkg::BASE_AUTO) begin
      case ($urandom_range(0, 2))
        0: begin
          put_char(rtp_pkg::CH_ZERO);
          put_char($urandom_range(0, 1) ? rtp_pkg::CH_X_LO : rtp_pkg::CH_X_UP);
          base = int'(rtp_pkg::BASE_HEX);
        end
        1: begin
          put_char(rtp_pkg::CH_ZERO);
          base = int'(rtp_pkg::BASE_OCT);
        end
        default: base = int'(rtp_pkg::BASE_DEC);
      endcase
    end
    // long runs can push the magnitude past the signed range
    nd = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 8);
    repeat (nd) put_char(digit_char(base <= 1 ? 0 :
                                     int'($urandom_range(0, (base > 16 ? 16 : base) - 1))));
    ends = $urandom_range(0, 19);
    if (ends >= 2) begin
      if (ends < 5 && base >= 1 && base < 16)
        put_char(digit_char(int'($urandom_range(base, 15))));
      else put_char(stop_char());
      repeat ($urandom_range(0, 2)) put_char(rtp_pkg::CH_W'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // ------------------------------------------------------------------ driver

  always @(posedge clk) begin : drive_chars
    bit fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_ch <= '0;
      in_start_req <= 1'b0;
      in_radix <= '0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) parse_char(cur_item);
      if (in_valid && !fire) begin
        // beat still waiting, keep it as it is
      end else if (char_queue.size() != 0 && !take_break() &&
                   !(char_queue[0].hold && parsed_results.size() != 0)) begin
        cur_item = char_queue.pop_front();
        in_ch <= cur_item.ch;
        in_start_req <= cur_item.start;
        in_radix <= cur_item.radix;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk) begin : watch_results
    parse_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (parsed_results.size() == 0) begin
          report_error($sformatf("unexpected result value %0d consumed %0d overflow %0b",
                                 out_value, out_consumed, out_overflow));
        end else begin
          want = parsed_results.pop_front();
          if (out_value !== want.value)
            report_error($sformatf("value: expected %0d, got %0d",
                                   $signed(want.value), out_value));
          if (out_consumed !== want.consumed)
            report_error($sformatf("consumed: expected %0d, got %0d",
                                   want.consumed, out_consumed));
          if (out_overflow !== want.overflow)
            report_error($sformatf("overflow: expected %0b, got %0b",
                                   want.overflow, out_overflow));
        end
      end
      out_ready <= !take_break();
    end
  end

  // -------------------------------------------------------------------- main

  initial begin
    // directed strings
    open_string(rtp_pkg::BASE_AUTO);
    put_text(" -0x1F;");
    open_string(rtp_pkg::BASE_AUTO);
    put_text("0X");
    put_char(8'h00);
    // tab is not skipped, then a stray character while done
    open_string(rtp_pkg::BASE_DEC);
    put_char(8'h09);
    put_char(rtp_pkg::CH_NINE, 1'b0);
    // octal string dropped by a fresh start in radix one
    open_string(rtp_pkg::BASE_AUTO);
    put_text("017");
    open_string(5'd1);
    put_text("+001");
    open_string(5'd31);
    put_text("fF0");
    put_char(8'hFF);

    hold_req = 1'b1;
    n_live = 0;
    while (n_live < LIVE_CHARS) begin
      if ($urandom_range(0, 99) == 0) hold_req = 1'b1;
      random_string();
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (char_queue.size() != 0 || in_valid || parsed_results.size() != 0)
      @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
